FILE: sv/blg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_pkg
// Shared types and constants for the three-LED battery gauge.
// ----------------------------------------------------------------------------
package blg_pkg;

    localparam int LEVEL_W = 8;
    localparam int TICK_W  = 6;
    localparam int STEP_W  = 3;
    localparam int PER_W   = 8;
    localparam int MASK_W  = 3;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_LOSE_THR   = 3'd0;
    localparam logic [IDX_W-1:0] REG_LOW_THR    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ONE_THR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_TWO_THR    = 3'd3;
    localparam logic [IDX_W-1:0] REG_FULL_THR   = 3'd4;
    localparam logic [IDX_W-1:0] REG_TICKS      = 3'd5;
    localparam logic [IDX_W-1:0] REG_DEPL_LIMIT = 3'd6;
    localparam logic [IDX_W-1:0] REG_IDLE_LIMIT = 3'd7;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] RST_LOSE_THR   = 8'd10;
    localparam logic [LEVEL_W-1:0] RST_LOW_THR    = 8'd20;
    localparam logic [LEVEL_W-1:0] RST_ONE_THR    = 8'd40;
    localparam logic [LEVEL_W-1:0] RST_TWO_THR    = 8'd70;
    localparam logic [LEVEL_W-1:0] RST_FULL_THR   = 8'd100;
    localparam logic [TICK_W-1:0]  RST_TICKS      = 6'd50;
    localparam logic [PER_W-1:0]   RST_DEPL_LIMIT = 8'd6;
    localparam logic [PER_W-1:0]   RST_IDLE_LIMIT = 8'd4;

    // LED patterns.
    localparam logic [MASK_W-1:0] MASK_NONE = 3'b000;
    localparam logic [MASK_W-1:0] MASK_ONE  = 3'b001;
    localparam logic [MASK_W-1:0] MASK_TWO  = 3'b011;
    localparam logic [MASK_W-1:0] MASK_ALL  = 3'b111;

    // Animation steps.
    localparam logic [STEP_W-1:0] STEP_ONE   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TWO   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_THREE = 3'd3;
    localparam logic [STEP_W-1:0] STEP_WRAP  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_MAX   = 3'd7;

    localparam logic [TICK_W-1:0] TICK_MAX = 6'd63;
    localparam logic [PER_W-1:0]  PER_MAX  = 8'd255;

    typedef struct packed {
        logic [LEVEL_W-1:0] lose_threshold;
        logic [LEVEL_W-1:0] low_threshold;
        logic [LEVEL_W-1:0] one_bar_threshold;
        logic [LEVEL_W-1:0] two_bar_threshold;
        logic [LEVEL_W-1:0] full_threshold;
        logic [TICK_W-1:0]  ticks_per_period;
        logic [PER_W-1:0]   depleted_flash_limit;
        logic [PER_W-1:0]   idle_period_limit;
    } blg_cfg_t;

    typedef struct packed {
        logic [TICK_W-1:0] charge_tick_count;
        logic [STEP_W-1:0] charge_step;
        logic [TICK_W-1:0] idle_tick_count;
        logic [PER_W-1:0]  depleted_periods;
        logic              blink_phase;
        logic [PER_W-1:0]  idle_periods;
        logic              display_active;
    } blg_state_t;

    typedef struct packed {
        logic [MASK_W-1:0] bar_mask;
        logic              all_on;
        logic              sleep_request;
        logic              display_enabled;
    } blg_result_t;

endpackage

FILE: sv/blg_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_step
// Next-state and LED result logic for one display tick.
// ----------------------------------------------------------------------------
module blg_step (
    input  blg_pkg::blg_cfg_t    cfg,
    input  blg_pkg::blg_state_t  state,
    input  logic [7:0]           battery_level,
    input  logic                 system_ready,
    input  logic                 usb_inserted,
    input  logic                 charge_complete,
    input  logic                 device_working,
    input  logic                 wake_display,
    output blg_pkg::blg_state_t  state_next,
    output blg_pkg::blg_result_t result
);
    import blg_pkg::*;

    logic              low;
    logic              lose;
    logic [TICK_W-1:0] ctc_inc;
    logic [TICK_W-1:0] itc_inc;
    logic [STEP_W-1:0] step_inc;
    logic [MASK_W-1:0] level_mask;

    assign low  = (battery_level <= cfg.low_threshold);
    assign lose = (battery_level <= cfg.lose_threshold);

    assign ctc_inc  = (state.charge_tick_count == TICK_MAX) ? TICK_MAX
                                                            : state.charge_tick_count + 1'b1;
    assign itc_inc  = (state.idle_tick_count == TICK_MAX) ? TICK_MAX
                                                          : state.idle_tick_count + 1'b1;
    assign step_inc = (state.charge_step == STEP_MAX) ? STEP_MAX
                                                      : state.charge_step + 1'b1;

    always_comb
    begin
        if (battery_level <= cfg.one_bar_threshold)
        begin
            level_mask = MASK_ONE;
        end
        else if (battery_level <= cfg.two_bar_threshold)
        begin
            level_mask = MASK_TWO;
        end
        else if (battery_level <= cfg.full_threshold)
        begin
            level_mask = MASK_ALL;
        end
        else
        begin
            level_mask = MASK_NONE;
        end
    end

    always_comb
    begin
        state_next = state;
        result     = '0;
        if (wake_display)
        begin
            state_next.display_active = 1'b1;
        end

        if (!system_ready)
        begin
            result.bar_mask = MASK_ALL;
            result.all_on   = 1'b1;
        end
        else if (usb_inserted)
        begin
            if (charge_complete)
            begin
                result.bar_mask = MASK_ALL;
            end
            else
            begin
                state_next.charge_tick_count = ctc_inc;
                if (ctc_inc >= cfg.ticks_per_period)
                begin
                    state_next.charge_tick_count = '0;
                    state_next.charge_step       = step_inc;
                    // The fill restarts from the present level, unless the
                    // level is above the full threshold.
                    if (step_inc >= STEP_WRAP)
                    begin
                        if (battery_level <= cfg.one_bar_threshold)
                        begin
                            state_next.charge_step = '0;
                        end
                        else if (battery_level <= cfg.two_bar_threshold)
                        begin
                            state_next.charge_step = STEP_ONE;
                        end
                        else if (battery_level <= cfg.full_threshold)
                        begin
                            state_next.charge_step = STEP_TWO;
                        end
                    end
                end
                case (state_next.charge_step)
                    STEP_ONE:   result.bar_mask = MASK_ONE;
                    STEP_TWO:   result.bar_mask = MASK_TWO;
                    STEP_THREE: result.bar_mask = MASK_ALL;
                    default:    result.bar_mask = MASK_NONE;
                endcase
            end
        end
        else
        begin
            state_next.charge_tick_count = '0;
            state_next.charge_step       = '0;

            if (low || !device_working)
            begin
                state_next.idle_tick_count = itc_inc;
                if (itc_inc >= cfg.ticks_per_period)
                begin
                    state_next.idle_tick_count = '0;
                    if (lose)
                    begin
                        state_next.depleted_periods = (state.depleted_periods == PER_MAX)
                            ? PER_MAX : state.depleted_periods + 1'b1;
                    end
                    else
                    begin
                        state_next.depleted_periods = '0;
                    end
                    if (low)
                    begin
                        state_next.blink_phase = ~state.blink_phase;
                    end
                    if (!device_working)
                    begin
                        state_next.idle_periods = (state.idle_periods == PER_MAX)
                            ? PER_MAX : state.idle_periods + 1'b1;
                    end
                    else
                    begin
                        state_next.idle_periods = '0;
                    end
                end
            end
            else
            begin
                state_next.idle_tick_count  = '0;
                state_next.depleted_periods = '0;
                state_next.idle_periods     = '0;
                state_next.blink_phase      = 1'b0;
            end

            if (low)
            begin
                if (state_next.blink_phase)
                begin
                    result.bar_mask = MASK_ALL;
                    result.all_on   = 1'b1;
                end
            end
            else
            begin
                result.bar_mask = level_mask;
            end

            if (!device_working)
            begin
                if (lose)
                begin
                    if (state_next.depleted_periods >= cfg.depleted_flash_limit)
                    begin
                        state_next.display_active = 1'b0;
                    end
                end
                else if (state_next.idle_periods >= cfg.idle_period_limit)
                begin
                    state_next.display_active = 1'b0;
                end
            end

            if (!state_next.display_active)
            begin
                result.bar_mask             = MASK_NONE;
                result.all_on               = 1'b0;
                result.sleep_request        = 1'b1;
                state_next.idle_tick_count  = '0;
                state_next.depleted_periods = '0;
                state_next.idle_periods     = '0;
                state_next.blink_phase      = 1'b0;
            end
        end
        result.display_enabled = state_next.display_active;
    end

endmodule

FILE: sv/battery_led_gauge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_led_gauge_unit
// Three-LED battery gauge with charge animation, low blink and sleep timer.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid, in_stall  | battery_level and the five tick flags
//  out     | out_valid, out_stall| bar_mask, all_on, sleep_request, display_enabled
//  cfg     | cfg_valid, cfg_ready| cfg_index, cfg_data
//
//  One tick word is taken per cycle while not stalled; its result is registered.
//  The gauge state updates in the same edge that takes the tick.
//  An output register plus a one-word skid stage let a new tick be taken
//  while a result waits; in_stall rises only when both hold words.
//  Reset restores the register defaults and the gauge state; cfg_ready is
//  always high.
// ----------------------------------------------------------------------------
module battery_led_gauge_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                battery_level,
    input  logic                      system_ready,
    input  logic                      usb_inserted,
    input  logic                      charge_complete,
    input  logic                      device_working,
    input  logic                      wake_display,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                bar_mask,
    output logic                      all_on,
    output logic                      sleep_request,
    output logic                      display_enabled,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [blg_pkg::IDX_W-1:0] cfg_index,
    input  logic [blg_pkg::DATA_W-1:0] cfg_data
);
    import blg_pkg::*;

    blg_cfg_t    cfg_reg;
    blg_state_t  state_reg;
    blg_state_t  state_next;
    blg_result_t step_result;
    blg_result_t out_reg;
    blg_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;
    logic        in_acc;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_acc    = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lose_threshold       <= RST_LOSE_THR;
            cfg_reg.low_threshold        <= RST_LOW_THR;
            cfg_reg.one_bar_threshold    <= RST_ONE_THR;
            cfg_reg.two_bar_threshold    <= RST_TWO_THR;
            cfg_reg.full_threshold       <= RST_FULL_THR;
            cfg_reg.ticks_per_period     <= RST_TICKS;
            cfg_reg.depleted_flash_limit <= RST_DEPL_LIMIT;
            cfg_reg.idle_period_limit    <= RST_IDLE_LIMIT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOSE_THR:   cfg_reg.lose_threshold       <= cfg_data;
                REG_LOW_THR:    cfg_reg.low_threshold        <= cfg_data;
                REG_ONE_THR:    cfg_reg.one_bar_threshold    <= cfg_data;
                REG_TWO_THR:    cfg_reg.two_bar_threshold    <= cfg_data;
                REG_FULL_THR:   cfg_reg.full_threshold       <= cfg_data;
                REG_TICKS:      cfg_reg.ticks_per_period     <= cfg_data[TICK_W-1:0];
                REG_DEPL_LIMIT: cfg_reg.depleted_flash_limit <= cfg_data;
                REG_IDLE_LIMIT: cfg_reg.idle_period_limit    <= cfg_data;
                default:        cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    blg_step u_step (
        .cfg             (cfg_reg),
        .state           (state_reg),
        .battery_level   (battery_level),
        .system_ready    (system_ready),
        .usb_inserted    (usb_inserted),
        .charge_complete (charge_complete),
        .device_working  (device_working),
        .wake_display    (wake_display),
        .state_next      (state_next),
        .result          (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{charge_tick_count: '0, charge_step: '0, idle_tick_count: '0,
                           depleted_periods: '0, blink_phase: 1'b0, idle_periods: '0,
                           display_active: 1'b1};
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    // Valid flags of the output register and the skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_acc;
            skid_valid_reg <= skid_valid_reg && in_acc;
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (in_acc)
                begin
                    skid_reg <= step_result;
                end
            end
            else if (in_acc)
            begin
                out_reg <= step_result;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= step_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign bar_mask        = out_reg.bar_mask;
    assign all_on          = out_reg.all_on;
    assign sleep_request   = out_reg.sleep_request;
    assign display_enabled = out_reg.display_enabled;

endmodule

FILE: sv/blg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blg_checker
// Port-level checks of the battery gauge, bound to the top level.
// ----------------------------------------------------------------------------
module blg_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [2:0]                 bar_mask,
    input logic                       all_on,
    input logic                       sleep_request,
    input logic                       display_enabled
);
    import blg_pkg::*;

    // A full display always shows every bar.
    a_all_on_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && all_on |-> bar_mask == MASK_ALL)
        else $error("all_on without a full bar mask");

    // A sleep word comes with the display off and dark.
    a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sleep_request |-> !display_enabled && bar_mask == MASK_NONE && !all_on)
        else $error("sleep request with the display lit");

    // Every taken tick leaves a result word waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted tick produced no result");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bar_mask) && $stable(all_on)
            && $stable(sleep_request) && $stable(display_enabled))
        else $error("stalled result word changed");

endmodule

bind battery_led_gauge_unit blg_checker u_blg_checker (.*);
